[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the key/value cache.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LKV_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LKV_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lkv_pkg.sv]
// Shared types and constants of the LRU key/value cache.
// No dependencies; used by every module of the block except lkv_ram.
package lkv_pkg;

    localparam int ENTRIES_DEFAULT  = 8;
    localparam int KEY_BITS_DEFAULT = 32;
    localparam int KEY_PORT_W       = 32;
    localparam int DATA_W           = 32;
    localparam int CAP_W            = 4;

    localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic                     op;
        logic [KEY_PORT_W-1:0]    key;
        logic signed [DATA_W-1:0] write_value;
    } lkv_in_t;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_value;
        logic [KEY_PORT_W-1:0]    front_key;
        logic                     front_valid;
    } lkv_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_RESP
    } lkv_state_t;

    typedef struct packed {
        logic start;
        logic commit;
        logic load_out;
    } lkv_cmd_t;

    typedef struct packed {
        logic scan_done;
    } lkv_status_t;

endpackage

[rtl/lru_key_value_cache.sv]
// Top level of the fully associative LRU key/value cache (lkv_ctrl, lkv_datapath).
// Depends on lkv_pkg, lkv_ram, lkv_datapath, lkv_ctrl and assert_macros.svh.
// Usage: the s_ channel takes one request beat (op, key, write_value); op insert
// stores or overwrites a value, op lookup returns hit and value and makes the
// entry most recent. Every request yields exactly one beat on the m_ channel
// with hit, read_value, the most recent key and whether the cache holds anything.
// cfg_wr_en writes the capacity register in the same cycle; write it only while
// no request is in flight. After acceptance the key scan reads one key RAM entry
// per cycle across all ENTRIES entries, then comes the update step and then the
// hand-off step, which loads the result register and raises m_valid. A new
// request is taken in the cycle after the result is loaded, so requests never
// overlap. A finished result sits in the output register while the next request
// is taken; if m_ready stays low the next result waits in the controller until
// the register frees up. Reset (aresetn, synchronous) empties the cache and sets
// capacity to eight; no RAM clearing pass is needed because valid bits guard
// every key and value read.
`include "assert_macros.svh"

module lru_key_value_cache #(
    parameter int ENTRIES  = lkv_pkg::ENTRIES_DEFAULT,
    parameter int KEY_BITS = lkv_pkg::KEY_BITS_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // Capacity register write port.
    input  logic                       cfg_wr_en,
    input  logic [lkv_pkg::CAP_W-1:0]  cfg_wr_data,
    // Request channel.
    input  logic                       s_valid,
    output logic                       s_ready,
    input  lkv_pkg::lkv_in_t           s_data,
    // Result channel.
    output logic                       m_valid,
    input  logic                       m_ready,
    output lkv_pkg::lkv_out_t          m_data
);

    lkv_pkg::lkv_cmd_t    cmd;
    lkv_pkg::lkv_status_t status;

    // The controller owns the handshakes and walks each request through
    // scan, update and result hand-off.
    lkv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath holds the entries, their recency ranks and the result register.
    lkv_datapath #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_beat     (s_data),
        .cmd         (cmd),
        .status      (status),
        .out_beat    (m_data)
    );

    // Once a beat is taken, no second beat may be taken until its result is built.
    `LKV_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready, "second request accepted during processing")
    // The end of the scan always leads straight into the update step.
    `LKV_ASSERT_NEXT(a_scan_then_commit, aclk, aresetn, status.scan_done, cmd.commit, "update did not follow scan")
    // A lookup hit makes an entry most recent, so the cache cannot be empty.
    `LKV_ASSERT_NOW(a_hit_nonempty, aclk, aresetn, m_valid && m_data.hit, m_data.front_valid, "hit reported on empty cache")

endmodule

[rtl/lkv_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lkv_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/lkv_datapath.sv]
// Datapath of the LRU key/value cache: key and value RAMs, valid bits, ranks,
// the sequential key scan and the result register. Depends on lkv_pkg, lkv_ram.
module lkv_datapath #(
    parameter int ENTRIES  = lkv_pkg::ENTRIES_DEFAULT,
    parameter int KEY_BITS = lkv_pkg::KEY_BITS_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [lkv_pkg::CAP_W-1:0]  cfg_wr_data,
    input  lkv_pkg::lkv_in_t           in_beat,
    input  lkv_pkg::lkv_cmd_t          cmd,
    output lkv_pkg::lkv_status_t       status,
    output lkv_pkg::lkv_out_t          out_beat
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > lkv_pkg::CAP_W) ? CNT_W : lkv_pkg::CAP_W;
    localparam int SK_W   = (KEY_BITS < lkv_pkg::KEY_PORT_W) ? KEY_BITS : lkv_pkg::KEY_PORT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // Configuration and latched request.
    logic [lkv_pkg::CAP_W-1:0]  capacity_reg;
    logic                       op_reg;
    logic [SK_W-1:0]            key_reg;
    logic [lkv_pkg::DATA_W-1:0] wval_reg;

    // Scan pipeline: read issue stage and compare stage.
    logic             scanning_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             cmp_vld_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             match_found_reg;
    logic [IDX_W-1:0] match_idx_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic [IDX_W-1:0] victim_idx_reg;

    // Replacement state.
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [RANK_W-1:0]  rank_reg  [ENTRIES];
    logic [RANK_W-1:0]  rank_next [ENTRIES];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [SK_W-1:0]    front_key_reg;

    lkv_pkg::lkv_out_t out_reg;

    logic [SK_W-1:0]            key_rdata;
    logic [lkv_pkg::DATA_W-1:0] val_rdata;

    logic [CNT_W-1:0]  cnt_m1;
    logic [RANK_W-1:0] victim_rank;
    logic [CMP_W-1:0]  cnt_ext;
    logic [CMP_W-1:0]  cap_ext;
    logic              is_insert;
    logic              ins_new;
    logic              do_evict;
    logic              promote;
    logic [IDX_W-1:0]  new_slot;
    logic [RANK_W-1:0] hit_rank;
    logic              key_we;
    logic              val_we;
    logic [IDX_W-1:0]  val_waddr;
    logic              val_re;
    logic              hit;

    assign cnt_m1      = count_reg - CNT_W'(1);
    assign victim_rank = cnt_m1[RANK_W-1:0];
    assign cnt_ext     = CMP_W'(count_reg);
    assign cap_ext     = CMP_W'(capacity_reg);

    assign is_insert = (op_reg == lkv_pkg::OP_INSERT);
    assign ins_new   = is_insert && !match_found_reg;
    assign promote   = !is_insert && match_found_reg;
    // A capacity of zero behaves as one: with a nonzero count, count >= 0 already holds.
    assign do_evict  = ins_new && (count_reg != '0) &&
                       ((cnt_ext >= CMP_W'(ENTRIES)) || (cnt_ext >= cap_ext));
    assign new_slot  = do_evict ? victim_idx_reg : free_idx_reg;
    assign hit_rank  = rank_reg[match_idx_reg];
    assign hit       = promote;

    assign key_we    = cmd.commit && ins_new;
    assign val_we    = cmd.commit && is_insert;
    assign val_waddr = match_found_reg ? match_idx_reg : new_slot;
    assign val_re    = cmd.commit && promote;

    lkv_ram #(
        .WIDTH (SK_W),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (new_slot),
        .wdata (key_reg),
        .re    (scanning_reg),
        .raddr (rd_idx_reg),
        .rdata (key_rdata)
    );

    lkv_ram #(
        .WIDTH (lkv_pkg::DATA_W),
        .DEPTH (ENTRIES)
    ) u_val_ram (
        .aclk  (aclk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (wval_reg),
        .re    (val_re),
        .raddr (match_idx_reg),
        .rdata (val_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= lkv_pkg::CAP_RESET;
        end else if (cfg_wr_en) begin
            capacity_reg <= cfg_wr_data;
        end
    end

    // Key scan. The compare stage checks each entry in the cycle after its RAM read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scanning_reg    <= 1'b0;
            rd_idx_reg      <= '0;
            cmp_vld_reg     <= 1'b0;
            cmp_idx_reg     <= '0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
        end else begin
            cmp_vld_reg <= scanning_reg;
            cmp_idx_reg <= rd_idx_reg;
            if (cmd.start) begin
                scanning_reg    <= 1'b1;
                rd_idx_reg      <= '0;
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
            end else begin
                if (scanning_reg) begin
                    if (rd_idx_reg == LAST_IDX) begin
                        scanning_reg <= 1'b0;
                    end else begin
                        rd_idx_reg <= rd_idx_reg + IDX_W'(1);
                    end
                end
                if (cmp_vld_reg) begin
                    if (valid_reg[cmp_idx_reg] && (key_rdata == key_reg) && !match_found_reg) begin
                        match_found_reg <= 1'b1;
                        match_idx_reg   <= cmp_idx_reg;
                    end
                    if (!valid_reg[cmp_idx_reg] && !free_found_reg) begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= cmp_idx_reg;
                    end
                    if (valid_reg[cmp_idx_reg] && (rank_reg[cmp_idx_reg] == victim_rank)) begin
                        victim_idx_reg <= cmp_idx_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg   <= in_beat.op;
            key_reg  <= in_beat.key[SK_W-1:0];
            wval_reg <= in_beat.write_value;
        end
    end

    // Rank update: a new key ages every held entry, a hit ages only the newer ones.
    always_comb begin
        valid_next = valid_reg;
        count_next = count_reg;
        for (int j = 0; j < ENTRIES; j++) begin
            rank_next[j] = rank_reg[j];
        end
        if (cmd.commit && ins_new) begin
            valid_next[new_slot] = 1'b1;
            if (!do_evict) begin
                count_next = count_reg + CNT_W'(1);
            end
            for (int j = 0; j < ENTRIES; j++) begin
                if (IDX_W'(j) == new_slot) begin
                    rank_next[j] = '0;
                end else if (valid_reg[j]) begin
                    rank_next[j] = rank_reg[j] + RANK_W'(1);
                end
            end
        end else if (cmd.commit && promote) begin
            for (int j = 0; j < ENTRIES; j++) begin
                if (IDX_W'(j) == match_idx_reg) begin
                    rank_next[j] = '0;
                end else if (valid_reg[j] && (rank_reg[j] < hit_rank)) begin
                    rank_next[j] = rank_reg[j] + RANK_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            count_reg     <= '0;
            front_key_reg <= '0;
            for (int j = 0; j < ENTRIES; j++) begin
                rank_reg[j] <= '0;
            end
        end else begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            for (int j = 0; j < ENTRIES; j++) begin
                rank_reg[j] <= rank_next[j];
            end
            if (cmd.commit && (ins_new || promote)) begin
                front_key_reg <= key_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg.hit         <= hit;
            out_reg.read_value  <= hit ? val_rdata : '0;
            out_reg.front_key   <= lkv_pkg::KEY_PORT_W'(front_key_reg);
            out_reg.front_valid <= (count_reg != '0);
        end
    end

    assign status.scan_done = cmp_vld_reg && (cmp_idx_reg == LAST_IDX);
    assign out_beat         = out_reg;

endmodule

[rtl/lkv_ctrl.sv]
// Controller of the LRU key/value cache: sequences accept, scan, update and
// result hand-off. Depends on lkv_pkg.
module lkv_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  lkv_pkg::lkv_status_t  status,
    output lkv_pkg::lkv_cmd_t     cmd
);

    lkv_pkg::lkv_state_t state_reg;
    lkv_pkg::lkv_state_t state_next;
    logic                m_valid_reg;
    logic                m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lkv_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        cmd          = '0;
        case (state_reg)
            lkv_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = lkv_pkg::ST_SCAN;
                end
            end
            lkv_pkg::ST_SCAN: begin
                if (status.scan_done) begin
                    state_next = lkv_pkg::ST_DECIDE;
                end
            end
            lkv_pkg::ST_DECIDE: begin
                cmd.commit = 1'b1;
                state_next = lkv_pkg::ST_RESP;
            end
            lkv_pkg::ST_RESP: begin
                // The result register is free, or its beat leaves this cycle.
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = lkv_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lkv_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

[verif/tb.sv]
// Self-checking testbench for the LRU key/value cache (lru_key_value_cache).
// Depends on lkv_pkg for the request and result types and on the RTL of the block.
// A software copy of the cache predicts each result beat and is compared with the DUT.
module tb;
    import lkv_pkg::*;

    localparam int ENTRIES       = ENTRIES_DEFAULT;
    // Long receiver hold-off, in cycles, used to fill the block and stall its input.
    localparam int HOLD_CYCLES   = 60;
    // Cycles without any handshake before the run is declared hung.
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_ITEMS   = 165;
    localparam int SETTLE_CYCLES = 2 * (ENTRIES + 4);

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CAP_W-1:0]      cfg_wr_data;
    logic                  s_valid;
    logic                  s_ready;
    lkv_in_t               s_data;
    logic                  m_valid;
    logic                  m_ready;
    lkv_out_t              m_data;

    // Results predicted at request acceptance, oldest first.
    lkv_out_t              expected_results[$];
    int                    fail_count;

    // Sender and receiver pacing controls, set by the test tasks.
    bit                    tx_steady;
    bit                    rx_steady;
    bit                    hold_request;

    // Predicted cache contents. Age 0 marks the most recent entry.
    logic [KEY_PORT_W-1:0] slot_key   [ENTRIES];
    logic [DATA_W-1:0]     slot_value [ENTRIES];
    bit                    slot_live  [ENTRIES];
    int unsigned           slot_age   [ENTRIES];
    int unsigned           live_count;
    logic [CAP_W-1:0]      capacity_setting;

    lru_key_value_cache DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Applies one request to the predicted cache and returns the result beat that
    // the DUT must produce for it.
    function automatic lkv_out_t cache_access(input lkv_in_t req);
        lkv_out_t    res;
        int          match;
        int          victim;
        int          free_slot;
        int unsigned limit;
        int unsigned oldest;
        int unsigned prev_age;
        res = '0;
        // A capacity of zero behaves as one, anything above the entry count as full size.
        if (capacity_setting == 0) begin
            limit = 1;
        end else if (capacity_setting > ENTRIES) begin
            limit = ENTRIES;
        end else begin
            limit = capacity_setting;
        end
        match = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (match < 0 && slot_live[i] && slot_key[i] == req.key) begin
                match = i;
            end
        end
        if (req.op == OP_INSERT) begin
            if (match >= 0) begin
                // Overwriting a held key leaves its recency alone.
                slot_value[match] = req.write_value;
            end else begin
                // At or above capacity, only the single oldest entry goes, so a
                // lowered capacity never shrinks the count.
                if (live_count >= limit && live_count > 0) begin
                    victim = -1;
                    oldest = 0;
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (slot_live[i] && (victim < 0 || slot_age[i] > oldest)) begin
                            victim = i;
                            oldest = slot_age[i];
                        end
                    end
                    if (victim >= 0) begin
                        slot_live[victim] = 1'b0;
                        live_count--;
                    end
                end
                free_slot = -1;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (free_slot < 0 && !slot_live[i]) begin
                        free_slot = i;
                    end
                end
                if (free_slot >= 0) begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (slot_live[i]) begin
                            slot_age[i]++;
                        end
                    end
                    slot_key[free_slot]   = req.key;
                    slot_value[free_slot] = req.write_value;
                    slot_live[free_slot]  = 1'b1;
                    slot_age[free_slot]   = 0;
                    live_count++;
                end
            end
        end else if (match >= 0) begin
            // A hit moves the entry to the front; everything newer ages by one.
            res.hit        = 1'b1;
            res.read_value = slot_value[match];
            prev_age       = slot_age[match];
            for (int i = 0; i < ENTRIES; i++) begin
                if (slot_live[i] && i != match && slot_age[i] < prev_age) begin
                    slot_age[i]++;
                end
            end
            slot_age[match] = 0;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (!res.front_valid && slot_live[i] && slot_age[i] == 0) begin
                res.front_key   = slot_key[i];
                res.front_valid = 1'b1;
            end
        end
        return res;
    endfunction

    // Offers one request beat after a random gap and returns at the edge where it
    // is accepted. Valid stays high across back-to-back beats; the caller must
    // change s_valid or s_data in the same time step so a beat is never sent twice.
    task automatic send_request(input logic op, input logic [KEY_PORT_W-1:0] key,
                                input logic [DATA_W-1:0] value);
        lkv_in_t req;
        int      gap;
        req.op          = op;
        req.key         = key;
        req.write_value = value;
        gap = tx_steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(cache_access(req));
    endtask

    // Stops offering beats and waits until every predicted result has been seen.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    // The capacity register is only written while the cache has nothing in flight.
    task automatic set_capacity(input logic [CAP_W-1:0] value);
        wait_for_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en        <= 1'b0;
        capacity_setting  = value;
    endtask

    // Lookup on an empty cache, key and value extremes, and a capacity of zero,
    // which must behave as a single-entry cache. A capacity of one follows.
    task automatic test_capacity_floor();
        set_capacity(4'd0);
        send_request(OP_LOOKUP, 32'h0000_0000, $urandom);
        send_request(OP_INSERT, 32'h0000_0000, 32'h8000_0000);
        send_request(OP_LOOKUP, 32'h0000_0000, $urandom);
        send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_request(OP_LOOKUP, 32'h0000_0000, $urandom);
        send_request(OP_LOOKUP, 32'hFFFF_FFFF, $urandom);
        send_request(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_LOOKUP, 32'hFFFF_FFFF, $urandom);
        set_capacity(4'd1);
        send_request(OP_INSERT, 32'hAAAA_AAAA, 32'h0000_0000);
        send_request(OP_LOOKUP, 32'hAAAA_AAAA, $urandom);
        send_request(OP_LOOKUP, 32'h5555_5555, $urandom);
    endtask

    // Fills all eight entries with fresh keys at an over-range capacity, then checks
    // that an update does not refresh recency and that a hit protects an entry.
    task automatic test_fill_and_evict();
        set_capacity(4'd15);
        for (int n = 0; n < ENTRIES; n++) begin
            send_request(OP_INSERT, 32'hC0DE_0000 + n, $urandom);
        end
        // The first fresh key is now the oldest; updating it must not save it.
        send_request(OP_INSERT, 32'hC0DE_0000, 32'h1234_5678);
        send_request(OP_INSERT, 32'hC0DE_0008, $urandom);
        send_request(OP_LOOKUP, 32'hC0DE_0000, $urandom);
        // A hit on the next oldest pushes eviction past it.
        send_request(OP_LOOKUP, 32'hC0DE_0001, $urandom);
        send_request(OP_INSERT, 32'hC0DE_0009, $urandom);
        send_request(OP_LOOKUP, 32'hC0DE_0002, $urandom);
        send_request(OP_LOOKUP, 32'hC0DE_0001, $urandom);
    endtask

    // Capacity lowered under the current count: each new key evicts one entry
    // and the count stays where it was.
    task automatic test_capacity_below_count();
        set_capacity(4'd2);
        send_request(OP_INSERT, 32'hC0DE_000A, $urandom);
        send_request(OP_INSERT, 32'hC0DE_000B, $urandom);
        send_request(OP_LOOKUP, 32'hC0DE_0003, $urandom);
        send_request(OP_LOOKUP, 32'hC0DE_0005, $urandom);
        send_request(OP_LOOKUP, 32'hC0DE_000A, $urandom);
    endtask

    // Random mix of inserts and lookups drawn mostly from a small key pool so that
    // hits, updates and evictions are all frequent, with some fully random keys.
    task automatic test_random_traffic(input logic [CAP_W-1:0] capacity, input int items);
        logic [KEY_PORT_W-1:0] key_pool [12];
        int                    pool_size;
        logic                  op;
        logic [KEY_PORT_W-1:0] key;
        logic [DATA_W-1:0]     value;
        set_capacity(capacity);
        pool_size = $urandom_range(2, 12);
        foreach (key_pool[i]) key_pool[i] = $urandom;
        if ($urandom_range(0, 2) == 0) key_pool[0] = '0;
        if ($urandom_range(0, 2) == 0) key_pool[1] = '1;
        // Some phases run with no idle cycles at all on one side or both.
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
        repeat (items) begin
            op  = ($urandom_range(0, 1) == 1) ? OP_LOOKUP : OP_INSERT;
            key = ($urandom_range(0, 7) == 0) ? $urandom
                                                : key_pool[$urandom_range(0, pool_size - 1)];
            case ($urandom_range(0, 9))
                0: value = 32'h8000_0000;
                1: value = 32'h7FFF_FFFF;
                2: value = 32'h0000_0000;
                default: value = $urandom;
            endcase
            send_request(op, key, value);
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // beats back to back, so the result path fills and the input stalls. The
    // sender then pauses until every result has drained.
    task automatic test_output_backpressure();
        hold_request = 1'b1;
        tx_steady    = 1'b1;
        for (int n = 0; n < 48; n++) begin
            send_request(n[0] ? OP_LOOKUP : OP_INSERT, 32'h0B0B_0000 + (n >> 1), $urandom);
        end
        tx_steady = 1'b0;
        wait_for_results();
    endtask

    // Result sink and checker. It pops the oldest prediction for each accepted
    // result beat and compares every field. The per-beat stall is drawn after each
    // acceptance; a hold-off request is counted down here in this process.
    initial begin : result_sink
        lkv_out_t want;
        int       rx_wait;
        int       hold_left;
        m_ready   = 1'b0;
        rx_wait   = 0;
        hold_left = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("unexpected result beat: hit %0d value %0d front %h/%0d",
                                 m_data.hit, m_data.read_value, m_data.front_key,
                                 m_data.front_valid);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.hit !== want.hit || m_data.read_value !== want.read_value ||
                        m_data.front_key !== want.front_key ||
                        m_data.front_valid !== want.front_valid) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("result mismatch: hit %0d/%0d value %0d/%0d",
                                     want.hit, m_data.hit, want.read_value,
                                     m_data.read_value);
                            $display("  front key %h/%h front valid %0d/%0d (expected/actual)",
                                     want.front_key, m_data.front_key,
                                     want.front_valid, m_data.front_valid);
                        end
                    end
                end
                rx_wait = rx_steady ? 0 : $urandom_range(0, 4);
            end
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Ends the run if no beat moves on either channel for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("FAIL lru_key_value_cache");
        $finish;
    end

    initial begin : stimulus
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_valid      = 1'b0;
        s_data       = '0;
        tx_steady    = 1'b0;
        rx_steady    = 1'b0;
        hold_request = 1'b0;
        fail_count   = 0;
        foreach (slot_live[i]) begin
            slot_live[i] = 1'b0;
            slot_age[i]  = 0;
        end
        live_count       = 0;
        capacity_setting = CAP_RESET;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The count only grows, so small capacities are exercised before the fill.
        test_capacity_floor();
        test_random_traffic(4'd3, PHASE_ITEMS);
        test_random_traffic(4'd5, PHASE_ITEMS);
        test_fill_and_evict();
        test_capacity_below_count();
        test_random_traffic(4'd8, PHASE_ITEMS);
        test_random_traffic(4'd0, PHASE_ITEMS);
        test_random_traffic(4'd15, PHASE_ITEMS);
        test_random_traffic(4'd2, PHASE_ITEMS);
        test_random_traffic(4'd1, PHASE_ITEMS);
        test_random_traffic(4'd6, PHASE_ITEMS);
        test_random_traffic(4'd12, PHASE_ITEMS);
        test_output_backpressure();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS lru_key_value_cache");
        end else begin
            $display("FAIL lru_key_value_cache");
        end
        $finish;
    end
endmodule

[sim.f]
+incdir+rtl
rtl/lkv_pkg.sv
rtl/lkv_ram.sv
rtl/lkv_datapath.sv
rtl/lkv_ctrl.sv
rtl/lru_key_value_cache.sv
verif/tb.sv
